// ----- rtl/oasm_pkg.sv -----
// ----------------------------------------------------------------------------
// oasm_pkg
// Shared constants, types and state encoding for the open address symbol map.
// ----------------------------------------------------------------------------
package oasm_pkg;

  localparam int SlotsDefault   = 256;
  localparam int KeyBitsDefault = 16;

  localparam int IdWidth      = 16;
  localparam int HashWidth    = 32;
  localparam int RefWidth     = 16;
  localparam int SlotOutWidth = 8;

  localparam int InDataWidth  = 64;
  localparam int OutDataWidth = 32;
  localparam int OutPadWidth  = OutDataWidth - RefWidth - 1 - SlotOutWidth;

  localparam logic ReqLookup = 1'b0;
  localparam logic ReqSet    = 1'b1;

  localparam logic StatusDone = 1'b0;
  localparam logic StatusFull = 1'b1;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StCheck,
    StResp
  } state_e;

  typedef struct packed {
    logic [RefWidth-1:0]     node_ref;
    logic                    hit;
    logic [SlotOutWidth-1:0] slot;
    logic                    status;
  } res_t;

endpackage

// ----- rtl/oasm_ram.sv -----
// ----------------------------------------------------------------------------
// oasm_ram
// Generic simple dual port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module oasm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/oasm_engine.sv -----
// ----------------------------------------------------------------------------
// oasm_engine
// Probe sequencer: clears the slot memory after reset, then walks the
// triangular probe sequence one slot per cycle and writes back on a set.
// ----------------------------------------------------------------------------
module oasm_engine #(
  parameter int SLOTS    = oasm_pkg::SlotsDefault,
  parameter int KEY_BITS = oasm_pkg::KeyBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   req_type_i,
  input  logic [oasm_pkg::IdWidth-1:0]           symbol_id_i,
  input  logic [oasm_pkg::HashWidth-1:0]         symbol_hash_i,
  input  logic [oasm_pkg::RefWidth-1:0]          node_ref_i,
  output logic [$clog2(SLOTS)-1:0]               ram_raddr_o,
  input  logic [KEY_BITS+oasm_pkg::RefWidth-1:0] ram_rdata_i,
  output logic                                   ram_we_o,
  output logic [$clog2(SLOTS)-1:0]               ram_waddr_o,
  output logic [KEY_BITS+oasm_pkg::RefWidth-1:0] ram_wdata_o,
  output logic                                   res_valid_o,
  input  logic                                   res_ready_i,
  output oasm_pkg::res_t                         res_o
);
  import oasm_pkg::*;

  localparam int SlotW = $clog2(SLOTS);

  state_e               state_q, state_d;
  logic [SlotW-1:0]     clr_q, clr_d;
  logic [SlotW-1:0]     idx_q, idx_d;
  logic [SlotW-1:0]     cnt_q, cnt_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [RefWidth-1:0]  ref_q, ref_d;
  logic                 set_q, set_d;
  res_t                 res_q, res_d;

  logic [KEY_BITS+IdWidth-1:0]     id_ext;
  logic [KEY_BITS-1:0]             key_in;
  logic [SlotW-1:0]                home;
  logic [SlotW+SlotOutWidth-1:0]   home_ext;
  logic [SlotW-1:0]                step;
  logic [SlotW-1:0]                idx_next;
  logic [SlotW+SlotOutWidth-1:0]   slot_ext;
  logic [KEY_BITS-1:0]             rd_key;
  logic [RefWidth-1:0]             rd_ref;
  logic                            rd_empty;
  logic                            rd_match;
  logic                            accept;

  assign id_ext   = {{KEY_BITS{1'b0}}, symbol_id_i};
  assign key_in   = id_ext[KEY_BITS-1:0];
  assign home     = symbol_hash_i[SlotW-1:0];
  assign home_ext = {{SlotOutWidth{1'b0}}, home};
  assign step     = cnt_q + 1'b1;
  assign idx_next = idx_q + step;
  assign slot_ext = {{SlotOutWidth{1'b0}}, idx_q};
  assign rd_key   = ram_rdata_i[KEY_BITS-1:0];
  assign rd_ref   = ram_rdata_i[KEY_BITS +: RefWidth];
  assign rd_empty = (rd_key == '0);
  assign rd_match = (rd_key == key_q);
  assign accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    key_q <= key_d;
    ref_q <= ref_d;
    set_q <= set_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    ref_d       = ref_q;
    set_d       = set_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    ram_raddr_o = idx_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = {ref_q, key_q};
    res_valid_o = 1'b0;
    unique case (state_q)
      StClear: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o  = 1'b1;
        ram_raddr_o = home;
        if (accept) begin
          idx_d = home;
          cnt_d = '0;
          key_d = key_in;
          ref_d = node_ref_i;
          set_d = (req_type_i == ReqSet);
          if (key_in == '0) begin
            res_d.node_ref = '0;
            res_d.hit      = 1'b0;
            res_d.slot     = home_ext[SlotOutWidth-1:0];
            res_d.status   = StatusDone;
            state_d        = StResp;
          end else begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (rd_empty || rd_match) begin
          res_d.node_ref = (rd_match && !set_q) ? rd_ref : '0;
          res_d.hit      = rd_match;
          res_d.slot     = slot_ext[SlotOutWidth-1:0];
          res_d.status   = StatusDone;
          ram_we_o       = set_q;
          state_d        = StResp;
        end else if (cnt_q == '1) begin
          res_d.node_ref = '0;
          res_d.hit      = 1'b0;
          res_d.slot     = '0;
          res_d.status   = StatusFull;
          state_d        = StResp;
        end else begin
          idx_d       = idx_next;
          cnt_d       = step;
          ram_raddr_o = idx_next;
        end
      end
      StResp: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign res_o = res_q;

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == StClear || state_q == StCheck))
    else $error("slot memory written outside clear or probe");

  a_no_empty_key_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we_o && state_q == StCheck) |-> (ram_wdata_o[KEY_BITS-1:0] != '0))
    else $error("set wrote an empty key");

  a_probe_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && key_in != '0) |=> (state_q == StCheck))
    else $error("nonzero key did not start probing");

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == StatusFull) |->
      (!res_o.hit && res_o.node_ref == '0 && res_o.slot == '0))
    else $error("table full result carries data");

endmodule

// ----- rtl/oasm_outbuf.sv -----
// ----------------------------------------------------------------------------
// oasm_outbuf
// Output register that packs one result item and holds it until taken.
// ----------------------------------------------------------------------------
module oasm_outbuf (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  oasm_pkg::res_t                    res_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [oasm_pkg::OutDataWidth-1:0] m_axis_tdata_o,
  output logic                              m_axis_tuser_o
);
  import oasm_pkg::*;

  logic valid_q, valid_d;
  res_t res_q, res_d;

  assign in_ready_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      res_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {{OutPadWidth{1'b0}}, res_q.slot, res_q.hit, res_q.node_ref};
  assign m_axis_tuser_o  = res_q.status;

endmodule

// ----- rtl/open_address_symbol_map.sv -----
// ----------------------------------------------------------------------------
// open_address_symbol_map
// Hash map from symbol ids to node references with triangular probing.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (low bit first)
// s_axis   in   tdata: symbol_id[15:0], symbol_hash[47:16], node_ref[63:48]
//               tuser: req_type (0 lookup, 1 set)
// m_axis   out  tdata: node_ref_out[15:0], hit[16], slot_index[24:17], zeros
//               tuser: status (0 done, 1 table full)
//
// A request probes P slots, P from 1 to SLOTS, and the slot memory gives
// one key per cycle. A zero symbol id is answered without any probing.
// After reset a clearing pass writes every slot empty, during which no
// item is accepted.
// A result waits in the output register; the next request may run meanwhile.
// ----------------------------------------------------------------------------
module open_address_symbol_map #(
  parameter int SLOTS    = oasm_pkg::SlotsDefault,
  parameter int KEY_BITS = oasm_pkg::KeyBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [oasm_pkg::InDataWidth-1:0]  s_axis_tdata_i,  // symbol_id, symbol_hash, node_ref
  input  logic                              s_axis_tuser_i,  // req_type
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [oasm_pkg::OutDataWidth-1:0] m_axis_tdata_o,  // node_ref_out, hit, slot_index
  output logic                              m_axis_tuser_o   // status
);
  import oasm_pkg::*;

  localparam int SlotW = $clog2(SLOTS);
  localparam int EntW  = KEY_BITS + RefWidth;

  logic [SlotW-1:0] ram_raddr;
  logic [SlotW-1:0] ram_waddr;
  logic [EntW-1:0]  ram_rdata;
  logic [EntW-1:0]  ram_wdata;
  logic             ram_we;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  oasm_ram #(
    .WIDTH (EntW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  oasm_engine #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .req_type_i    (s_axis_tuser_i),
    .symbol_id_i   (s_axis_tdata_i[IdWidth-1:0]),
    .symbol_hash_i (s_axis_tdata_i[IdWidth +: HashWidth]),
    .node_ref_i    (s_axis_tdata_i[IdWidth+HashWidth +: RefWidth]),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  oasm_outbuf u_outbuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (res_valid),
    .in_ready_o      (res_ready),
    .res_i           (res),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
